FILE: design/sdiv_pkg.sv
// shared types and constants for the signed integer divider
// no dependencies
`timescale 1ns / 1ps

package sdiv_pkg;

  localparam int DATA_WIDTH_DEF = 32;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CALC,
    S_FIX
  } sdiv_state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } sdiv_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic last_step;
    logic out_free;
  } sdiv_sts_t;

endpackage

FILE: design/sdiv_ctrl.sv
// controller state machine for the signed integer divider
// depends on sdiv_pkg
`timescale 1ns / 1ps

module sdiv_ctrl
  import sdiv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  output sdiv_cmd_t  cmd,
  input  sdiv_sts_t  sts
);

  sdiv_state_t state_r;
  sdiv_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        if (sts.last_step) begin
          state_nxt = S_FIX;
        end
      end
      S_FIX: begin
        if (sts.out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.finish = 1'b0;
    case (state_r)
      S_IDLE: begin
        // no transaction is taken while in reset
        in_ready = rst_n;
        cmd.load = in_valid & rst_n;
      end
      S_CALC: begin
        cmd.step = 1'b1;
      end
      S_FIX: begin
        cmd.finish = sts.out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // at most one command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.step, cmd.finish}))
    else $error("sdiv_ctrl: more than one command");

  // a loaded transaction always goes into the iteration phase
  a_load_calc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_CALC))
    else $error("sdiv_ctrl: load not followed by iteration");

  // the last iteration hands over to the result write
  a_last_fix: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.step && sts.last_step) |=> (state_r == S_FIX))
    else $error("sdiv_ctrl: last step did not reach fix-up");

endmodule

FILE: design/sdiv_dp.sv
// datapath for the signed integer divider: magnitudes, restoring iteration,
// sign fix-up and output register; depends on sdiv_pkg
`timescale 1ns / 1ps

module sdiv_dp
  import sdiv_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic signed [DATA_WIDTH-1:0] in_dividend,
  input  logic signed [DATA_WIDTH-1:0] in_divisor,
  input  sdiv_cmd_t                    cmd,
  output sdiv_sts_t                    sts,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_quotient
);

  localparam int CW = $clog2(DATA_WIDTH);

  logic [DATA_WIDTH-1:0] a_u;
  logic [DATA_WIDTH-1:0] b_u;
  logic [DATA_WIDTH-1:0] a_mag;
  logic [DATA_WIDTH-1:0] b_mag;

  // num_r shifts dividend bits out at the top and quotient bits in at the bottom
  logic [DATA_WIDTH-1:0] num_r;
  logic [DATA_WIDTH-1:0] den_r;
  logic [DATA_WIDTH-1:0] rem_r;
  logic [CW-1:0]         cnt_r;
  logic                  neg_r;
  logic                  dzero_r;

  logic [DATA_WIDTH:0]   rem_sh;
  logic [DATA_WIDTH:0]   diff;
  logic                  q_bit;

  logic [DATA_WIDTH-1:0] result;
  logic [DATA_WIDTH-1:0] out_q_r;
  logic                  out_valid_r;

  assign a_u   = in_dividend;
  assign b_u   = in_divisor;
  assign a_mag = a_u[DATA_WIDTH-1] ? (~a_u + 1'b1) : a_u;
  assign b_mag = b_u[DATA_WIDTH-1] ? (~b_u + 1'b1) : b_u;

  assign rem_sh = {rem_r, num_r[DATA_WIDTH-1]};
  assign diff   = rem_sh - {1'b0, den_r};
  assign q_bit  = ~diff[DATA_WIDTH];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num_r   <= a_mag;
      den_r   <= b_mag;
      rem_r   <= '0;
      cnt_r   <= CW'(DATA_WIDTH - 1);
      neg_r   <= a_u[DATA_WIDTH-1] ^ b_u[DATA_WIDTH-1];
      dzero_r <= (b_u == '0);
    end else if (cmd.step) begin
      num_r <= {num_r[DATA_WIDTH-2:0], q_bit};
      rem_r <= q_bit ? diff[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // sign fix-up, zero divisor and overflow saturation
  always_comb begin
    if (dzero_r) begin
      result = '0;
    end else if (neg_r) begin
      result = ~num_r + 1'b1;
    end else if (num_r[DATA_WIDTH-1]) begin
      result = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    end else begin
      result = num_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      out_q_r <= result;
    end
  end

  assign sts.last_step = (cnt_r == '0);
  assign sts.out_free  = ~out_valid_r | out_ready;
  assign out_valid     = out_valid_r;
  assign out_quotient  = out_q_r;

  // a new result never overwrites one that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_ready))
    else $error("sdiv_dp: result overwritten");

  // a waiting result holds its value until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_q_r)))
    else $error("sdiv_dp: pending result changed");

endmodule

FILE: design/signed_int_divider.sv
// signed integer divider, quotient truncated toward zero
// a new transaction is accepted only in idle, after the previous result is written;
// the radix-2 loop retires one quotient bit per cycle in the shared subtractor
// reset: rst_n synchronous active low, returns the controller to idle and
// empties the output register; depends on sdiv_pkg, sdiv_ctrl, sdiv_dp
`timescale 1ns / 1ps

module signed_int_divider
  import sdiv_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel: one transaction carries dividend and divisor
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] in_dividend,
  input  logic signed [DATA_WIDTH-1:0] in_divisor,
  // result channel: one quotient per input transaction
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] out_quotient
);

  sdiv_cmd_t cmd;
  sdiv_sts_t sts;

  // controller: idle -> iterate over the quotient bits -> write result register,
  // then idle again so the next transaction can enter while the result waits
  sdiv_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // datapath: operand magnitudes, restoring division, sign and special cases
  sdiv_dp #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_dividend  (in_dividend),
    .in_divisor   (in_divisor),
    .cmd          (cmd),
    .sts          (sts),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_quotient (out_quotient)
  );

endmodule
